// ----- design/rvw_pkg.sv -----
// Shared types and constants for the RV64 word-op and load/store execute block.
`timescale 1ns / 1ps

package rvw_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);

  // Major opcodes
  localparam logic [6:0] OPC_OP32    = 7'h3B;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;

  // funct7 patterns
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 patterns
  localparam logic [2:0] F3_ADD    = 3'b000;
  localparam logic [2:0] F3_SL     = 3'b001;
  localparam logic [2:0] F3_SR     = 3'b101;
  localparam logic [2:0] F3_DOUBLE = 3'b011;
  localparam logic [2:0] F3_WORDU  = 3'b110;

  // Input item kinds
  localparam logic REQ_EXEC = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [31:0]     instruction_word;
    logic [XLEN-1:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic              wrote_reg;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              mem_request;
    logic              mem_is_write;
    logic              mem_wide;
    logic [XLEN-1:0]   mem_address;
    logic [XLEN-1:0]   store_data;
    logic              illegal;
  } out_item_t;

  // Outstanding load bookkeeping
  typedef struct packed {
    logic              valid;
    logic [REG_AW-1:0] dest;
    logic              wide;
  } pend_t;

endpackage

// ----- design/rvw_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module rvw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- design/rvw_exec.sv -----
// Decode and execute of one item: word ALU, address add, load return.
`timescale 1ns / 1ps

module rvw_exec import rvw_pkg::*; (
  input  in_item_t        item_i,
  input  logic [XLEN-1:0] rs1_val_i,
  input  logic [XLEN-1:0] rs2_val_i,
  input  pend_t           pend_i,
  output out_item_t       res_o,
  output pend_t           pend_o
);

  logic [31:0]       iw;
  logic [6:0]        opc;
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [REG_AW-1:0] rs2;
  logic [6:0]        f7;
  logic [31:0]       a;
  logic [31:0]       b;
  logic [XLEN-1:0]   imm_i;
  logic [XLEN-1:0]   imm_s;
  logic [4:0]        sh_reg;
  logic [31:0]       r32;
  logic              ok;
  logic [XLEN-1:0]   wval;
  logic              wen;
  logic [REG_AW-1:0] wdst;

  // Field extraction
  assign iw     = item_i.instruction_word;
  assign opc    = iw[6:0];
  assign rd     = iw[11:7];
  assign f3     = iw[14:12];
  assign rs2    = iw[24:20];
  assign f7     = iw[31:25];
  assign a      = rs1_val_i[31:0];
  assign b      = rs2_val_i[31:0];
  assign sh_reg = b[4:0];
  assign imm_i  = {{(XLEN-12){iw[31]}}, iw[31:20]};
  assign imm_s  = {{(XLEN-12){iw[31]}}, iw[31:25], iw[11:7]};

  // Compute result and next pending-load state
  always_comb begin
    res_o  = '0;
    pend_o = pend_i;
    r32    = '0;
    ok     = 1'b0;
    wen    = 1'b0;
    wdst   = rd;
    wval   = '0;
    if (item_i.req_type == REQ_LOAD) begin
      if (pend_i.valid) begin
        pend_o.valid = 1'b0;
        wen  = 1'b1;
        wdst = pend_i.dest;
        wval = pend_i.wide ? item_i.load_data : {32'b0, item_i.load_data[31:0]};
      end else begin
        res_o.illegal = 1'b1;
      end
    end else begin
      case (opc)
        OPC_OP32: begin
          if (f3 == F3_ADD && f7 == F7_BASE) begin
            r32 = a + b;
            ok  = 1'b1;
          end else if (f3 == F3_ADD && f7 == F7_ALT) begin
            r32 = a - b;
            ok  = 1'b1;
          end else if (f3 == F3_SL && f7 == F7_BASE) begin
            r32 = a << sh_reg;
            ok  = 1'b1;
          end else if (f3 == F3_SR && f7 == F7_BASE) begin
            r32 = a >> sh_reg;
            ok  = 1'b1;
          end else if (f3 == F3_SR && f7 == F7_ALT) begin
            r32 = $signed(a) >>> sh_reg;
            ok  = 1'b1;
          end
        end
        OPC_OPIMM32: begin
          if (f3 == F3_ADD) begin
            r32 = a + imm_i[31:0];
            ok  = 1'b1;
          end else if (f3 == F3_SL && f7 == F7_BASE) begin
            r32 = a << rs2;
            ok  = 1'b1;
          end else if (f3 == F3_SR && f7 == F7_BASE) begin
            r32 = a >> rs2;
            ok  = 1'b1;
          end else if (f3 == F3_SR && f7 == F7_ALT) begin
            r32 = $signed(a) >>> rs2;
            ok  = 1'b1;
          end
        end
        OPC_LOAD: begin
          if (f3 == F3_DOUBLE || f3 == F3_WORDU) begin
            pend_o.valid      = 1'b1;
            pend_o.dest       = rd;
            pend_o.wide       = (f3 == F3_DOUBLE);
            res_o.mem_request = 1'b1;
            res_o.mem_wide    = (f3 == F3_DOUBLE);
            res_o.mem_address = rs1_val_i + imm_i;
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OPC_STORE: begin
          if (f3 == F3_DOUBLE) begin
            res_o.mem_request  = 1'b1;
            res_o.mem_is_write = 1'b1;
            res_o.mem_wide     = 1'b1;
            res_o.mem_address  = rs1_val_i + imm_s;
            res_o.store_data   = rs2_val_i;
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        default: begin
          res_o.illegal = 1'b1;
        end
      endcase
      if (opc == OPC_OP32 || opc == OPC_OPIMM32) begin
        if (ok) begin
          wen  = 1'b1;
          wval = {{(XLEN-32){r32[31]}}, r32};
        end else begin
          res_o.illegal = 1'b1;
        end
      end
    end
    // Drop writes to x0
    if (wen && wdst != '0) begin
      res_o.wrote_reg  = 1'b1;
      res_o.dest_reg   = wdst;
      res_o.dest_value = wval;
    end
  end

endmodule

// ----- design/rv64_word_op_and_load_store_exec.sv -----
// Top level: RV64 word-op and load/store execute block.
// A result passes through the input register, then the result register, which
// holds while the output is stalled. Throughput: one item per cycle unless the
// output stalls; the register-file read is registered at accept.
// Reset clears the register valid bits (all registers read zero), the pending
// load and the stage valids; there is no clearing pass over the register file.
`timescale 1ns / 1ps

module rv64_word_op_and_load_store_exec import rvw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic              in_acc;
  logic              s1_valid_q;
  in_item_t          s1_item_q;
  logic              s1_adv;
  logic              out_valid_q;
  out_item_t         out_item_q;
  out_item_t         res;
  pend_t             pend_q;
  pend_t             pend_d;
  logic [NUM_REGS-1:0] reg_valid_q;
  logic              byp_valid_q;
  logic [REG_AW-1:0] byp_addr_q;
  logic [XLEN-1:0]   byp_data_q;
  logic [XLEN-1:0]   ram_a;
  logic [XLEN-1:0]   ram_b;
  logic [REG_AW-1:0] rs1;
  logic [REG_AW-1:0] rs2;
  logic [XLEN-1:0]   rs1_val;
  logic [XLEN-1:0]   rs2_val;
  logic              reg_we;

  // Handshake: the execute stage moves when the output slot is free or draining
  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign reg_we     = s1_adv && res.wrote_reg;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  // Register file storage, read at accept
  rvw_ram #(
    .Width (XLEN),
    .Depth (NUM_REGS)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (reg_we),
    .waddr_i   (res.dest_reg),
    .wdata_i   (res.dest_value),
    .re_i      (in_acc),
    .raddr_a_i (in_item_i.instruction_word[19:15]),
    .raddr_b_i (in_item_i.instruction_word[24:20]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Written flags and forwarding of the most recent write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_valid_q <= '0;
      byp_valid_q <= 1'b0;
    end else if (reg_we) begin
      reg_valid_q[res.dest_reg] <= 1'b1;
      byp_valid_q               <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      byp_addr_q <= res.dest_reg;
      byp_data_q <= res.dest_value;
    end
  end

  // Operand select: x0, forwarded write, stored value, or never-written zero
  assign rs1 = s1_item_q.instruction_word[19:15];
  assign rs2 = s1_item_q.instruction_word[24:20];

  always_comb begin
    if (rs1 == '0) begin
      rs1_val = '0;
    end else if (byp_valid_q && byp_addr_q == rs1) begin
      rs1_val = byp_data_q;
    end else if (reg_valid_q[rs1]) begin
      rs1_val = ram_a;
    end else begin
      rs1_val = '0;
    end
    if (rs2 == '0) begin
      rs2_val = '0;
    end else if (byp_valid_q && byp_addr_q == rs2) begin
      rs2_val = byp_data_q;
    end else if (reg_valid_q[rs2]) begin
      rs2_val = ram_b;
    end else begin
      rs2_val = '0;
    end
  end

  rvw_exec u_exec (
    .item_i    (s1_item_q),
    .rs1_val_i (rs1_val),
    .rs2_val_i (rs2_val),
    .pend_i    (pend_q),
    .res_o     (res),
    .pend_o    (pend_d)
  );

  // Pending load state advances with the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (s1_adv) begin
      pend_q <= pend_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- design/rvw_chk.sv -----
// Port-level assertions for the execute block, bound to the top level.
`timescale 1ns / 1ps

module rvw_chk import rvw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // x0 is never reported as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.wrote_reg |-> out_item_o.dest_reg != '0)
    else $error("write reported to x0");

  // An illegal item carries no write and no memory access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.illegal |->
      !out_item_o.wrote_reg && !out_item_o.mem_request && out_item_o.dest_value == '0)
    else $error("illegal item has side effects");

  // Memory fields are zero without a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.mem_request |->
      out_item_o.mem_address == '0 && out_item_o.store_data == '0 &&
      !out_item_o.mem_wide && !out_item_o.mem_is_write)
    else $error("memory fields set without request");

  // A store is always a wide access and never writes a register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mem_is_write |->
      out_item_o.mem_request && out_item_o.mem_wide && !out_item_o.wrote_reg)
    else $error("malformed store");

endmodule

bind rv64_word_op_and_load_store_exec rvw_chk u_chk (.*);
